/* hdl/scc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types, codes and constants of the starter crank controller.
// ----------------------------------------------------------------------------
package scc_pkg;

  // Milliseconds per second and the width of a limit held in milliseconds
  localparam int unsigned MsPerSecond = 1000;
  localparam int unsigned LimW        = 18;   // 255 * 1000 fits in 18 bits

  // Field widths
  localparam int unsigned TimeW = 32;
  localparam int unsigned RpmW  = 16;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned CfgIdxW = 2;

  // Stream data widths (packed fields rounded up to whole bytes)
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 8;

  // Reset values of the configuration registers
  localparam logic [RpmW-1:0] RpmThrRst    = 16'd400;
  localparam logic [LimW-1:0] CrankLimRst  = 18'd5000;
  localparam logic [LimW-1:0] CoolLimRst   = 18'd10000;
  localparam logic            ActLevelRst  = 1'b1;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_RPM_THR   = 2'd0,
    CFG_CRANK_SEC = 2'd1,
    CFG_COOL_SEC  = 2'd2,
    CFG_ACT_LEVEL = 2'd3
  } cfg_idx_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CRANK = 2'd1,
    ST_COOL  = 2'd2
  } state_e;

  // Start request outcome codes
  typedef enum logic [1:0] {
    SO_NONE     = 2'd0,
    SO_STARTED  = 2'd1,
    SO_RUNNING  = 2'd2,
    SO_COOLDOWN = 2'd3
  } start_outcome_e;

  // Stop cause codes
  typedef enum logic [1:0] {
    SC_NONE    = 2'd0,
    SC_MANUAL  = 2'd1,
    SC_TIMEOUT = 2'd2,
    SC_ENGINE  = 2'd3
  } stop_cause_e;

  // Configuration as seen by the update logic
  typedef struct packed {
    logic [RpmW-1:0] rpm_thr;
    logic [LimW-1:0] crank_lim_ms;
    logic [LimW-1:0] cool_lim_ms;
    logic            act_level;
  } cfg_t;

  // One update beat
  typedef struct packed {
    logic             stop_request;
    logic             start_request;
    logic [RpmW-1:0]  engine_rpm;
    logic [TimeW-1:0] now_ms;
  } item_t;

  // One result beat
  typedef struct packed {
    stop_cause_e    stop_cause;
    start_outcome_e start_outcome;
    logic           in_cooldown;
    logic           is_cranking;
    logic           relay_level;
  } res_t;

endpackage

/* hdl/scc_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_cfg_regs
// Configuration registers; second counts are kept as millisecond limits.
// ----------------------------------------------------------------------------
module scc_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [scc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [scc_pkg::CfgW-1:0]          cfg_wdata_i,
  output scc_pkg::cfg_t                     cfg_o
);

  scc_pkg::cfg_t                  cfg_q;
  scc_pkg::cfg_t                  cfg_d;
  logic [scc_pkg::LimW-1:0]       wr_lim_ms;

  // Scale the written seconds to milliseconds
  assign wr_lim_ms = scc_pkg::LimW'(cfg_wdata_i[7:0])
                   * scc_pkg::LimW'(scc_pkg::MsPerSecond);

  // Select the register to write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (scc_pkg::cfg_idx_e'(cfg_idx_i))
        scc_pkg::CFG_RPM_THR:   cfg_d.rpm_thr      = cfg_wdata_i[scc_pkg::RpmW-1:0];
        scc_pkg::CFG_CRANK_SEC: cfg_d.crank_lim_ms = wr_lim_ms;
        scc_pkg::CFG_COOL_SEC:  cfg_d.cool_lim_ms  = wr_lim_ms;
        scc_pkg::CFG_ACT_LEVEL: cfg_d.act_level    = cfg_wdata_i[0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rpm_thr      <= scc_pkg::RpmThrRst;
      cfg_q.crank_lim_ms <= scc_pkg::CrankLimRst;
      cfg_q.cool_lim_ms  <= scc_pkg::CoolLimRst;
      cfg_q.act_level    <= scc_pkg::ActLevelRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/scc_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_update
// Relay state machine: applies stop, start, crank and cooldown checks of one
// update beat and produces its result.
// ----------------------------------------------------------------------------
module scc_update (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,     // commit this beat's state update
  input  scc_pkg::item_t  item_i,
  input  scc_pkg::cfg_t   cfg_i,
  output scc_pkg::res_t   res_o
);

  scc_pkg::state_e             state_q, state_d;
  logic [scc_pkg::TimeW-1:0]   crank_t0_q, crank_t0_d;
  logic [scc_pkg::TimeW-1:0]   cool_t0_q, cool_t0_d;

  // Next state, stamps and cause codes
  always_comb begin
    logic                      running;
    logic                      started;
    logic                      cool_set;
    logic [scc_pkg::TimeW-1:0] crank_el;
    logic [scc_pkg::TimeW-1:0] cool_el;
    scc_pkg::start_outcome_e   outcome;
    scc_pkg::stop_cause_e      cause;

    running    = item_i.engine_rpm >= cfg_i.rpm_thr;
    started    = 1'b0;
    cool_set   = 1'b0;
    outcome    = scc_pkg::SO_NONE;
    cause      = scc_pkg::SC_NONE;
    state_d    = state_q;
    crank_t0_d = crank_t0_q;
    cool_t0_d  = cool_t0_q;

    // Manual stop
    if (item_i.stop_request && state_d == scc_pkg::ST_CRANK) begin
      state_d  = scc_pkg::ST_COOL;
      cool_set = 1'b1;
      cause    = scc_pkg::SC_MANUAL;
    end

    // Start request; engine running wins over cooldown
    if (item_i.start_request) begin
      priority if (state_d == scc_pkg::ST_IDLE && !running) begin
        state_d = scc_pkg::ST_CRANK;
        started = 1'b1;
        outcome = scc_pkg::SO_STARTED;
      end else if (running) begin
        outcome = scc_pkg::SO_RUNNING;
      end else if (state_d == scc_pkg::ST_COOL) begin
        outcome = scc_pkg::SO_COOLDOWN;
      end else begin
        outcome = scc_pkg::SO_NONE;
      end
    end

    // Crank timeout, then engine caught
    crank_el = started ? '0 : item_i.now_ms - crank_t0_q;
    if (state_d == scc_pkg::ST_CRANK) begin
      priority if (crank_el >= scc_pkg::TimeW'(cfg_i.crank_lim_ms)) begin
        state_d  = scc_pkg::ST_COOL;
        cool_set = 1'b1;
        cause    = scc_pkg::SC_TIMEOUT;
      end else if (running) begin
        state_d  = scc_pkg::ST_COOL;
        cool_set = 1'b1;
        cause    = scc_pkg::SC_ENGINE;
      end else begin
        state_d  = scc_pkg::ST_CRANK;
      end
    end

    // End of cooldown
    cool_el = cool_set ? '0 : item_i.now_ms - cool_t0_q;
    if (state_d == scc_pkg::ST_COOL &&
        cool_el >= scc_pkg::TimeW'(cfg_i.cool_lim_ms)) begin
      state_d = scc_pkg::ST_IDLE;
    end

    if (started)  crank_t0_d = item_i.now_ms;
    if (cool_set) cool_t0_d  = item_i.now_ms;

    res_o.is_cranking   = (state_d == scc_pkg::ST_CRANK);
    res_o.in_cooldown   = (state_d == scc_pkg::ST_COOL);
    res_o.relay_level   = res_o.is_cranking ? cfg_i.act_level : ~cfg_i.act_level;
    res_o.start_outcome = outcome;
    res_o.stop_cause    = cause;
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= scc_pkg::ST_IDLE;
      crank_t0_q <= '0;
      cool_t0_q  <= '0;
    end else if (adv_i) begin
      state_q    <= state_d;
      crank_t0_q <= crank_t0_d;
      cool_t0_q  <= cool_t0_d;
    end
  end

endmodule

/* hdl/starter_crank_controller_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// starter_crank_controller_unit
// Engine starter relay sequencer with idle, cranking and cooldown states.
// ----------------------------------------------------------------------------
// One update beat is taken every clock cycle while the result side does not
// stall. A beat is captured in the input register, decided by the relay state
// machine while it waits there and presented from the output register.
// Backpressure on the result side stalls both stages. Configuration writes
// take effect on the next clock and belong to times when no beat is in flight.
module starter_crank_controller_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Update beats
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // now_ms[31:0], engine_rpm[47:32], start_request[48], stop_request[49], zeros
  input  logic [scc_pkg::InDataW-1:0]       s_axis_tdata,
  // Result beats
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // relay_level[0], is_cranking[1], in_cooldown[2], start_outcome[4:3],
  // stop_cause[6:5], zero[7]
  output logic [scc_pkg::OutDataW-1:0]      m_axis_tdata,
  // Configuration writes
  input  logic                              cfg_we_i,
  input  logic [scc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [scc_pkg::CfgW-1:0]          cfg_wdata_i
);

  scc_pkg::cfg_t  cfg;
  scc_pkg::item_t in_q;
  scc_pkg::res_t  res;
  scc_pkg::res_t  out_q;
  logic           in_vld_q;
  logic           out_vld_q;
  logic           adv;
  logic           in_take;

  // Advance when the output register is free or being drained
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  scc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  scc_update u_upd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register: hold the beat until the state machine takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.now_ms        <= s_axis_tdata[31:0];
      in_q.engine_rpm    <= s_axis_tdata[47:32];
      in_q.start_request <= s_axis_tdata[48];
      in_q.stop_request  <= s_axis_tdata[49];
    end
  end

  // Output register: load a fresh result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q.stop_cause, out_q.start_outcome,
                          out_q.in_cooldown, out_q.is_cranking, out_q.relay_level};

  // Cranking and cooldown never show together
  a_state_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.is_cranking && out_q.in_cooldown))
    else $error("result shows cranking and cooldown together");

  // Any stop leaves the starter disengaged
  a_stop_disengages: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.stop_cause != scc_pkg::SC_NONE) |-> !out_q.is_cranking)
    else $error("starter still engaged after a stop");

  // A waiting input beat is never lost while the output is stalled
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> in_vld_q)
    else $error("input beat dropped under backpressure");

endmodule
